@@ hdl/hist_eq_pkg.sv @@
package hist_eq_pkg;

    localparam int BINS      = 256;
    localparam int BIN_W     = 8;
    localparam int NUM_LANES = 4;
    localparam int NUM_CHAN  = 3;
    localparam int FRAC_BITS = 8;

    // memory lanes: one histogram each
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;
    localparam int LANE_VALUE = 3;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_COUNT = 2'd1,
        CMD_BUILD = 2'd2,
        CMD_MAP   = 2'd3
    } cmd_t;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_CLEAR   = 9'b000000010,
        ST_CNT_RD  = 9'b000000100,
        ST_CNT_WR  = 9'b000001000,
        ST_BUILD   = 9'b000010000,
        ST_MAP_RD  = 9'b000100000,
        ST_MAP_MUL = 9'b001000000,
        ST_MAP_DIV = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

endpackage

@@ hdl/histogram_equalizer.sv @@
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_cmd, s_red_in, s_green_in, s_blue_in, s_alpha_in
// m_        out        m_valid / m_ready   m_red_out, m_green_out, m_blue_out, m_alpha_out,
//                                          m_count_saturated
// cfg_      in         cfg_we              cfg_wdata (color_mode)
//
// Clear and build sweep all 256 entries of the four bin memories, one per cycle;
// map runs one restoring divider per channel on a shared divisor, one quotient bit per cycle.
// After reset a clearing pass over all bins runs before s_ready first rises.
// A finished result waits in the output register; the next transaction is taken
// meanwhile and stalls only in its final state if the previous result is still held.
module histogram_equalizer
    import hist_eq_pkg::*;
#(
    parameter int COUNT_WIDTH = 24
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [7:0] s_red_in,
    input  logic [7:0] s_green_in,
    input  logic [7:0] s_blue_in,
    input  logic [7:0] s_alpha_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_red_out,
    output logic [7:0] m_green_out,
    output logic [7:0] m_blue_out,
    output logic [7:0] m_alpha_out,
    output logic       m_count_saturated
);

    localparam int CW = COUNT_WIDTH;
    localparam int XW = CW + BIN_W;      // dividend / divisor width
    localparam int RW = XW + 1;          // partial remainder width
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
    localparam logic [2:0] DIV_LAST = 3'(FRAC_BITS - 1);
    localparam logic [BIN_W:0] SWEEP_END = (BIN_W+1)'(BINS);
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BINS - 1);

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic   mode_reg;

    logic [BIN_W-1:0] pix_reg [NUM_LANES];     // r, g, b, v
    logic [BIN_W-1:0] pix_next [NUM_LANES];
    logic [7:0]       alpha_reg, alpha_next;

    logic [CW-1:0] total_reg, total_next;
    logic          flag_reg, flag_next;
    logic [BIN_W:0] sweep_reg, sweep_next;
    logic [CW-1:0] acc_reg [NUM_LANES];
    logic [CW-1:0] acc_next [NUM_LANES];

    logic [XW-1:0] d_reg, d_next;
    logic          zero_reg, zero_next;
    logic [RW-1:0] rem_reg [NUM_CHAN];
    logic [RW-1:0] rem_next [NUM_CHAN];
    logic [7:0]    q_reg [NUM_CHAN];
    logic [7:0]    q_next [NUM_CHAN];
    logic          ovf_reg [NUM_CHAN];
    logic          ovf_next [NUM_CHAN];
    logic [2:0]    div_cnt_reg, div_cnt_next;

    logic [7:0] out_reg [NUM_LANES];
    logic [7:0] out_next [NUM_LANES];
    logic       out_sat_reg, out_sat_next;
    logic       m_valid_reg, m_valid_next;

    // bin memories
    logic [CW-1:0]    mem [NUM_LANES][BINS];
    logic [CW-1:0]    rd_data [NUM_LANES];
    logic [BIN_W-1:0] rd_addr [NUM_LANES];
    logic [BIN_W-1:0] wr_addr [NUM_LANES];
    logic [CW-1:0]    wr_data [NUM_LANES];
    logic             wr_en [NUM_LANES];

    logic [BIN_W-1:0] v_in;

    assign v_in = (s_red_in > s_green_in)
        ? ((s_blue_in > s_red_in) ? s_blue_in : s_red_in)
        : ((s_blue_in > s_green_in) ? s_blue_in : s_green_in);

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (wr_en[l]) begin
                mem[l][wr_addr[l]] <= wr_data[l];
            end
            rd_data[l] <= mem[l][rd_addr[l]];
        end
    end

    always_comb begin
        logic [CW:0]   sum;
        logic [CW-1:0] sat_sum;
        logic [RW-1:0] d_ext;
        logic [RW-1:0] sh;
        logic [XW-1:0] x;

        state_next   = state_reg;
        cmd_next     = cmd_reg;
        alpha_next   = alpha_reg;
        total_next   = total_reg;
        flag_next    = flag_reg;
        sweep_next   = sweep_reg;
        d_next       = d_reg;
        zero_next    = zero_reg;
        div_cnt_next = div_cnt_reg;
        out_sat_next = out_sat_reg;
        m_valid_next = m_valid_reg && !m_ready;
        d_ext        = {1'b0, d_reg};
        sum          = '0;
        sat_sum      = '0;
        sh           = '0;
        x            = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            pix_next[l] = pix_reg[l];
            acc_next[l] = acc_reg[l];
            out_next[l] = out_reg[l];
            rd_addr[l]  = pix_reg[l];
            wr_addr[l]  = pix_reg[l];
            wr_data[l]  = '0;
            wr_en[l]    = 1'b0;
        end
        for (int c = 0; c < NUM_CHAN; c++) begin
            rem_next[c] = rem_reg[c];
            q_next[c]   = q_reg[c];
            ovf_next[c] = ovf_reg[c];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next    = cmd_t'(s_cmd);
                    pix_next[LANE_RED]   = s_red_in;
                    pix_next[LANE_GREEN] = s_green_in;
                    pix_next[LANE_BLUE]  = s_blue_in;
                    pix_next[LANE_VALUE] = v_in;
                    alpha_next  = s_alpha_in;
                    sweep_next  = '0;
                    unique case (cmd_t'(s_cmd))
                        CMD_CLEAR: state_next = ST_CLEAR;
                        CMD_COUNT: state_next = ST_CNT_RD;
                        CMD_BUILD: begin
                            state_next = ST_BUILD;
                            for (int l = 0; l < NUM_LANES; l++) begin
                                acc_next[l] = '0;
                            end
                        end
                        CMD_MAP:   state_next = ST_MAP_RD;
                    endcase
                end
            end
            ST_CLEAR: begin
                for (int l = 0; l < NUM_LANES; l++) begin
                    wr_en[l]   = 1'b1;
                    wr_addr[l] = sweep_reg[BIN_W-1:0];
                end
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg[BIN_W-1:0] == LAST_BIN) begin
                    total_next = '0;
                    flag_next  = 1'b0;
                    // the pass after reset returns no result
                    state_next = (cmd_reg == CMD_CLEAR) ? ST_DONE : ST_IDLE;
                end
            end
            ST_CNT_RD: state_next = ST_CNT_WR;
            ST_CNT_WR: begin
                for (int l = 0; l < NUM_LANES; l++) begin
                    if ((l == LANE_VALUE) == mode_reg) begin
                        wr_en[l] = 1'b1;
                        if (rd_data[l] == CNT_MAX) begin
                            wr_data[l] = CNT_MAX;
                            flag_next  = 1'b1;
                        end else begin
                            wr_data[l] = rd_data[l] + 1'b1;
                        end
                    end
                end
                if (total_reg == CNT_MAX) begin
                    flag_next = 1'b1;
                end else begin
                    total_next = total_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_BUILD: begin
                // read bin k while writing the running sum of bin k-1
                for (int l = 0; l < NUM_LANES; l++) begin
                    sum     = {1'b0, acc_reg[l]} + {1'b0, rd_data[l]};
                    sat_sum = sum[CW] ? CNT_MAX : sum[CW-1:0];
                    rd_addr[l] = sweep_reg[BIN_W-1:0];
                    wr_addr[l] = BIN_W'(sweep_reg - 1'b1);
                    wr_data[l] = sat_sum;
                    if (sweep_reg != '0) begin
                        wr_en[l]    = 1'b1;
                        acc_next[l] = sat_sum;
                        if (sum[CW]) begin
                            flag_next = 1'b1;
                        end
                    end
                end
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == SWEEP_END) begin
                    state_next = ST_DONE;
                end
            end
            ST_MAP_RD: state_next = ST_MAP_MUL;
            ST_MAP_MUL: begin
                if (mode_reg) begin
                    d_next = XW'(total_reg) * XW'(pix_reg[LANE_VALUE]);
                end else begin
                    d_next = XW'(total_reg);
                end
                zero_next = (total_reg == '0) || (mode_reg && pix_reg[LANE_VALUE] == '0);
                for (int c = 0; c < NUM_CHAN; c++) begin
                    if (mode_reg) begin
                        x = XW'(pix_reg[c]) * XW'(rd_data[LANE_VALUE]);
                    end else begin
                        x = XW'(rd_data[c]);
                    end
                    rem_next[c] = RW'(x);
                    q_next[c]   = '0;
                    ovf_next[c] = 1'b0;
                end
                div_cnt_next = '0;
                state_next   = ST_MAP_DIV;
            end
            ST_MAP_DIV: begin
                for (int c = 0; c < NUM_CHAN; c++) begin
                    if (div_cnt_reg == '0 && rem_reg[c] >= d_ext) begin
                        ovf_next[c] = 1'b1;
                    end
                    sh = {rem_reg[c][RW-2:0], 1'b0};
                    if (sh >= d_ext) begin
                        rem_next[c] = sh - d_ext;
                        q_next[c]   = {q_reg[c][6:0], 1'b1};
                    end else begin
                        rem_next[c] = sh;
                        q_next[c]   = {q_reg[c][6:0], 1'b0};
                    end
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    for (int c = 0; c < NUM_CHAN; c++) begin
                        if (cmd_reg != CMD_MAP || zero_reg) begin
                            out_next[c] = '0;
                        end else if (ovf_reg[c]) begin
                            out_next[c] = 8'hff;
                        end else begin
                            out_next[c] = q_reg[c];
                        end
                    end
                    out_next[NUM_CHAN] = (cmd_reg == CMD_MAP) ? alpha_reg : 8'h00;
                    out_sat_next = flag_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cmd_reg     <= CMD_COUNT;
            mode_reg    <= 1'b0;
            total_reg   <= '0;
            flag_reg    <= 1'b0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            total_reg   <= total_next;
            flag_reg    <= flag_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        alpha_reg   <= alpha_next;
        d_reg       <= d_next;
        zero_reg    <= zero_next;
        div_cnt_reg <= div_cnt_next;
        out_sat_reg <= out_sat_next;
        for (int l = 0; l < NUM_LANES; l++) begin
            pix_reg[l] <= pix_next[l];
            acc_reg[l] <= acc_next[l];
            out_reg[l] <= out_next[l];
        end
        for (int c = 0; c < NUM_CHAN; c++) begin
            rem_reg[c] <= rem_next[c];
            q_reg[c]   <= q_next[c];
            ovf_reg[c] <= ovf_next[c];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_red_out         = out_reg[LANE_RED];
    assign m_green_out       = out_reg[LANE_GREEN];
    assign m_blue_out        = out_reg[LANE_BLUE];
    assign m_alpha_out       = out_reg[NUM_CHAN];
    assign m_count_saturated = out_sat_reg;

`ifndef ASSERT_OFF
    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAP_DIV && div_cnt_reg == DIV_LAST) |=> state_reg == ST_DONE)
        else $error("divider did not finish after last quotient bit");

    a_clear_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && cmd_reg == CMD_CLEAR) |-> !flag_reg && total_reg == '0)
        else $error("clear left saturation flag or total set");

    a_sweep_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BUILD) |-> sweep_reg <= SWEEP_END)
        else $error("build sweep ran past the last bin");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_ready)) |=> m_valid && s_ready)
        else $error("finished transaction not presented");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import hist_eq_pkg::*;

    localparam int CW        = 24;
    localparam logic [CW-1:0] CNT_TOP = {CW{1'b1}};
    localparam int N_ITEMS   = 1750;
    localparam int IDLE_LIMIT = 3000;  // covers the sweep commands plus the long output hold
    localparam int HOLD_LEN  = 400;    // long receiver back-pressure stretch

    typedef struct {
        cmd_t       cmd;
        logic [7:0] r, g, b, a;
    } pixel_cmd_t;

    typedef struct {
        logic [7:0] r, g, b, a;
        logic       sat;
    } eq_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_cmd = 2'd0;
    logic [7:0] s_red_in = 8'd0, s_green_in = 8'd0, s_blue_in = 8'd0, s_alpha_in = 8'd0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_red_out, m_green_out, m_blue_out, m_alpha_out;
    logic m_count_saturated;

    histogram_equalizer #(.COUNT_WIDTH(CW)) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_red_in         (s_red_in),
        .s_green_in       (s_green_in),
        .s_blue_in        (s_blue_in),
        .s_alpha_in       (s_alpha_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_red_out        (m_red_out),
        .m_green_out      (m_green_out),
        .m_blue_out       (m_blue_out),
        .m_alpha_out      (m_alpha_out),
        .m_count_saturated(m_count_saturated)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Shadow state of the equalizer: four histograms, total, flag, mode
    // ---------------------------------------------------------------
    logic [CW-1:0] hist [4][BINS];
    logic [CW-1:0] px_total;
    logic          sat_seen;
    logic          eq_mode;

    pixel_cmd_t pending_px[$];   // waiting to be driven
    eq_result_t expected_px[$];  // predicted, not yet seen on m_
    int unsigned errors = 0;
    int unsigned queued = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests = 0;

    function automatic logic [CW-1:0] bump(logic [CW-1:0] x);
        if (x == CNT_TOP) begin
            sat_seen = 1'b1;
            return x;
        end
        return x + 1'b1;
    endfunction

    function automatic logic [7:0] clip255(logic [63:0] x);
        return (x > 64'd255) ? 8'd255 : x[7:0];
    endfunction

    function automatic eq_result_t equalize(pixel_cmd_t p);
        eq_result_t res;
        logic [7:0] v;
        logic [63:0] acc, den, cum;
        res = '{default: '0};
        v = (p.r > p.g) ? p.r : p.g;
        if (p.b > v) v = p.b;
        case (p.cmd)
            CMD_CLEAR: begin
                foreach (hist[l, i]) hist[l][i] = '0;
                px_total = '0;
                sat_seen = 1'b0;
            end
            CMD_COUNT: begin
                if (!eq_mode) begin
                    hist[LANE_RED][p.r]   = bump(hist[LANE_RED][p.r]);
                    hist[LANE_GREEN][p.g] = bump(hist[LANE_GREEN][p.g]);
                    hist[LANE_BLUE][p.b]  = bump(hist[LANE_BLUE][p.b]);
                end else begin
                    hist[LANE_VALUE][v] = bump(hist[LANE_VALUE][v]);
                end
                px_total = bump(px_total);
            end
            CMD_BUILD: begin
                // running sums, clamped at the counter ceiling
                for (int l = 0; l < NUM_LANES; l++) begin
                    acc = 0;
                    for (int i = 0; i < BINS; i++) begin
                        acc += hist[l][i];
                        if (acc > CNT_TOP) begin
                            acc = CNT_TOP;
                            sat_seen = 1'b1;
                        end
                        hist[l][i] = acc[CW-1:0];
                    end
                end
            end
            default: begin
                if (px_total != 0) begin
                    if (!eq_mode) begin
                        res.r = clip255({hist[LANE_RED][p.r], 8'd0} / px_total);
                        res.g = clip255({hist[LANE_GREEN][p.g], 8'd0} / px_total);
                        res.b = clip255({hist[LANE_BLUE][p.b], 8'd0} / px_total);
                    end else if (v != 0) begin
                        // scale each channel by cum[v] / (total * v)
                        cum = hist[LANE_VALUE][v];
                        den = 64'(px_total) * 64'(v);
                        res.r = clip255((64'(p.r) * 256 * cum) / den);
                        res.g = clip255((64'(p.g) * 256 * cum) / den);
                        res.b = clip255((64'(p.b) * 256 * cum) / den);
                    end
                end
                res.a = p.a;
            end
        endcase
        res.sat = sat_seen;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Driver: one transaction held per slot, refilled from pending_px
    // ---------------------------------------------------------------
    pixel_cmd_t on_bus;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_px.push_back(equalize(on_bus));
            if (!s_valid || s_ready) begin
                if (pending_px.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = pending_px.pop_front();
                    s_cmd      <= on_bus.cmd;
                    s_red_in   <= on_bus.r;
                    s_green_in <= on_bus.g;
                    s_blue_in  <= on_bus.b;
                    s_alpha_in <= on_bus.a;
                    s_valid    <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random back-pressure, long hold on request, field compare
    // ---------------------------------------------------------------
    int unsigned hold_left = 0;
    int unsigned holds_taken = 0;
    eq_result_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_px.size() == 0) begin
                    $error("unexpected result transaction");
                    errors++;
                end else begin
                    want = expected_px.pop_front();
                    if (m_red_out !== want.r) begin
                        $error("red_out exp %0d got %0d", want.r, m_red_out);
                        errors++;
                    end
                    if (m_green_out !== want.g) begin
                        $error("green_out exp %0d got %0d", want.g, m_green_out);
                        errors++;
                    end
                    if (m_blue_out !== want.b) begin
                        $error("blue_out exp %0d got %0d", want.b, m_blue_out);
                        errors++;
                    end
                    if (m_alpha_out !== want.a) begin
                        $error("alpha_out exp %0d got %0d", want.a, m_alpha_out);
                        errors++;
                    end
                    if (m_count_saturated !== want.sat) begin
                        $error("count_saturated exp %0d got %0d", want.sat, m_count_saturated);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (holds_taken < hold_requests) begin
                holds_taken <= holds_taken + 1;
                hold_left <= HOLD_LEN;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog: stop if neither channel moves for too long
    int unsigned quiet = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet <= 0;
        else if (quiet >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else
            quiet <= quiet + 1;
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic send(cmd_t c, logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        pixel_cmd_t p;
        p.cmd = c; p.r = r; p.g = g; p.b = b; p.a = a;
        pending_px.push_back(p);
        queued++;
    endtask

    // random pixel; a small palette now and then piles counts into few bins
    task automatic send_px(cmd_t c);
        if ($urandom_range(3) == 0)
            send(c, 8'($urandom_range(3) * 85), 8'($urandom_range(3) * 85),
                 8'($urandom_range(3) * 85), 8'($urandom));
        else
            send(c, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // block drained; every transaction yields a result, so a short margin suffices
    task automatic drain();
        while (pending_px.size() > 0 || s_valid || expected_px.size() > 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_mode(logic m);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        eq_mode = m;
        cfg_we <= 1'b0;
    endtask

    // one frame: clear, count pass, build, map pass, with some noise
    task automatic frame(int unsigned n_count, int unsigned n_map);
        int unsigned k;
        send(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        for (k = 0; k < n_count; k++) send_px(CMD_COUNT);
        if ($urandom_range(5) == 0) set_mode(1'($urandom_range(1)));  // mode set at random after counting
        send(CMD_BUILD, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        if ($urandom_range(9) == 0)
            send(CMD_BUILD, 8'd0, 8'd0, 8'd0, 8'd0);
        for (k = 0; k < n_map; k++) begin
            if ($urandom_range(19) == 0)
                send_px(cmd_t'($urandom_range(3)));
            else
                send_px(CMD_MAP);
        end
    endtask

    initial begin
        int unsigned ph;
        foreach (hist[l, i]) hist[l][i] = '0;
        px_total = '0;
        sat_seen = 1'b0;
        eq_mode = 1'b0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty map, extremes, repeated build, black pixel, both modes
        set_mode(1'b0);
        send(CMD_MAP,   8'd255, 8'd0,   8'd128, 8'd255);
        send(CMD_COUNT, 8'd0,   8'd0,   8'd0,   8'd0);
        send(CMD_COUNT, 8'd255, 8'd255, 8'd255, 8'd255);
        send(CMD_COUNT, 8'hAA,  8'h55,  8'h0F,  8'hF0);
        send(CMD_MAP,   8'd0,   8'd255, 8'hAA,  8'h5A);
        send(CMD_BUILD, 8'd0,   8'd0,   8'd0,   8'd0);
        send(CMD_MAP,   8'd0,   8'd255, 8'hAA,  8'hA5);
        send(CMD_BUILD, 8'd0,   8'd0,   8'd0,   8'd0);
        send(CMD_MAP,   8'd255, 8'd255, 8'd255, 8'd0);
        send(CMD_CLEAR, 8'd0,   8'd0,   8'd0,   8'd0);
        set_mode(1'b1);
        send(CMD_MAP,   8'd10,  8'd20,  8'd30,  8'd7);
        send(CMD_COUNT, 8'd0,   8'd0,   8'd0,   8'd1);
        send(CMD_COUNT, 8'd255, 8'd1,   8'd2,   8'd2);
        send(CMD_COUNT, 8'd3,   8'd200, 8'd4,   8'd3);
        send(CMD_MAP,   8'd0,   8'd0,   8'd0,   8'd99);
        send(CMD_MAP,   8'd3,   8'd200, 8'd4,   8'd9);
        send(CMD_BUILD, 8'd0,   8'd0,   8'd0,   8'd0);
        send(CMD_MAP,   8'd255, 8'd1,   8'd2,   8'd128);
        send(CMD_MAP,   8'd1,   8'd1,   8'd1,   8'd64);
        set_mode(1'b0);   // bins counted in value mode, read in RGB mode
        send(CMD_MAP,   8'd255, 8'd200, 8'd3,   8'd32);

        // random phases: free run, sender gaps, receiver stalls, both
        ph = 0;
        while (queued < N_ITEMS) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            set_mode(1'(ph % 2));
            if (ph == 2)
                hold_requests++;   // long back-pressure while the sender keeps offering
            for (int f = 0; f < 4; f++)
                frame($urandom_range(1, ($urandom_range(7) == 0) ? 120 : 30),
                      $urandom_range(1, 40));
            ph++;
        end

        drain();
        repeat (300) @(posedge aclk);
        if (errors == 0 && expected_px.size() == 0)
            $display("ALL CHECKS PASSED");
        else begin
            if (expected_px.size() != 0)
                $error("%0d result transactions never arrived", expected_px.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
